@@ rtl/fcm_pkg.sv @@
package fcm_pkg;

  // sizes of the frame, command table and argument slots
  localparam int MAX_FRAME    = 8;
  localparam int MAX_COMMANDS = 6;
  localparam int MAX_ARGS     = 3;
  localparam int ARG_IDX_W    = $clog2(MAX_ARGS);
  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_W    = $clog2(JOB_DEPTH);

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_COMMAND_COUNT = 3'd1;
  localparam logic [2:0] CFG_MASK_BASE     = 3'd2;

  // input opcodes
  localparam logic OPC_BYTE  = 1'b0;
  localparam logic OPC_FLUSH = 1'b1;

  // result kinds
  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_DUMP    = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] command_index;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
    logic [7:0] dumped_byte;
    logic       last;
  } out_item_t;

  typedef logic [MAX_FRAME-1:0][7:0] frame_t;
  typedef logic [MAX_ARGS-1:0][7:0]  args_t;

  typedef enum logic [1:0] {
    JOB_FWD  = 2'd0,
    JOB_CMD  = 2'd1,
    JOB_DUMP = 2'd2
  } job_kind_t;

  // work handed from the classifier to the result sequencer
  typedef struct packed {
    job_kind_t  kind;
    logic [2:0] cmd_idx;
    args_t      args;
    frame_t     bytes;
    logic [3:0] len;
  } job_t;

endpackage

@@ rtl/fcm_front.sv @@
module fcm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             in_accept,
  input  fcm_pkg::in_item_t in_item,
  output logic             job_push,
  output fcm_pkg::job_t    job
);
  import fcm_pkg::*;

  logic [3:0]  frame_length_r;
  logic [2:0]  command_count_r;
  logic [63:0] mask_r [MAX_COMMANDS];
  logic [2:0]  fill_r, fill_nxt;
  logic [7:0]  store_r [MAX_FRAME];

  logic [3:0]  len_eff;
  logic [2:0]  ncmd_eff;
  frame_t      frame_cur;
  logic [3:0]  fill_inc;
  logic        complete;
  logic        store_wr;
  logic [MAX_COMMANDS-1:0] pass;
  args_t       caps [MAX_COMMANDS];
  logic        found;
  logic [2:0]  found_idx;

  // byte of the frame matches the mask byte, or the mask byte is a wildcard
  function automatic logic mask_pass(logic [63:0] mask, frame_t fr, logic [3:0] len);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < MAX_FRAME; j++) begin
      if (4'(j) < len && mask[8*j +: 8] != 8'h00 && mask[8*j +: 8] != fr[j]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // collect the first wildcard bytes in frame order
  function automatic args_t mask_caps(logic [63:0] mask, frame_t fr, logic [3:0] len);
    args_t      c;
    logic [3:0] n;
    c = '0;
    n = '0;
    for (int j = 0; j < MAX_FRAME; j++) begin
      if (4'(j) < len && mask[8*j +: 8] == 8'h00 && n < 4'(MAX_ARGS)) begin
        c[n[ARG_IDX_W-1:0]] = fr[j];
        n = n + 4'd1;
      end
    end
    return c;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= 4'd1;
      command_count_r <= 3'd0;
      for (int k = 0; k < MAX_COMMANDS; k++) mask_r[k] <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_FRAME_LENGTH) frame_length_r <= cfg_data[3:0];
      if (cfg_index == CFG_COMMAND_COUNT) command_count_r <= cfg_data[2:0];
      for (int k = 0; k < MAX_COMMANDS; k++) begin
        if (cfg_index == CFG_MASK_BASE + 3'(k)) mask_r[k] <= cfg_data;
      end
    end
  end

  // clamp the configured sizes
  always_comb begin
    len_eff = frame_length_r;
    if (len_eff == 4'd0) len_eff = 4'd1;
    if (len_eff > 4'(MAX_FRAME)) len_eff = 4'(MAX_FRAME);
    ncmd_eff = command_count_r;
    if (ncmd_eff > 3'(MAX_COMMANDS)) ncmd_eff = 3'(MAX_COMMANDS);
  end

  // frame as seen with the arriving byte in place
  always_comb begin
    fill_inc = {1'b0, fill_r} + 4'd1;
    store_wr = {1'b0, fill_r} < len_eff;
    complete = fill_inc >= len_eff;
    for (int j = 0; j < MAX_FRAME; j++) begin
      frame_cur[j] = (store_wr && fill_r == 3'(j)) ? in_item.rx_byte : store_r[j];
    end
  end

  // compare against every mask in parallel
  always_comb begin
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      pass[i] = mask_pass(mask_r[i], frame_cur, len_eff);
      caps[i] = mask_caps(mask_r[i], frame_cur, len_eff);
    end
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < MAX_COMMANDS; i++) begin
      if (!found && 3'(i) < ncmd_eff && pass[i]) begin
        found     = 1'b1;
        found_idx = 3'(i);
      end
    end
  end

  // classify the transaction and build the job
  always_comb begin
    job_push     = 1'b0;
    job          = '0;
    job.kind     = JOB_FWD;
    fill_nxt     = fill_r;
    if (in_accept) begin
      if (in_item.opcode == OPC_FLUSH) begin
        fill_nxt = '0;
      end else if (ncmd_eff == 3'd0) begin
        job_push     = 1'b1;
        job.kind     = JOB_FWD;
        job.bytes[0] = in_item.rx_byte;
        job.len      = 4'd1;
      end else if (complete) begin
        job_push = 1'b1;
        fill_nxt = '0;
        job.len  = len_eff;
        if (found) begin
          job.kind    = JOB_CMD;
          job.cmd_idx = found_idx;
          job.args    = caps[found_idx];
        end else begin
          job.kind  = JOB_DUMP;
          job.bytes = frame_cur;
        end
      end else begin
        fill_nxt = fill_inc[2:0];
      end
    end
  end

  // fill counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // frame bytes
  always_ff @(posedge clk) begin
    if (in_accept && in_item.opcode == OPC_BYTE && ncmd_eff != 3'd0 && store_wr) begin
      store_r[fill_r] <= in_item.rx_byte;
    end
  end

endmodule

@@ rtl/fcm_job_fifo.sv @@
module fcm_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  fcm_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd,
  output logic          avail,
  output fcm_pkg::job_t rd_job
);
  import fcm_pkg::*;

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wptr_r, rptr_r;
  logic [JOB_PTR_W:0]   count_r;

  assign full   = count_r == (JOB_PTR_W + 1)'(JOB_DEPTH);
  assign avail  = count_r != '0;
  assign rd_job = mem_r[rptr_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr) wptr_r <= wptr_r + JOB_PTR_W'(1);
      if (rd) rptr_r <= rptr_r + JOB_PTR_W'(1);
      if (wr && !rd) count_r <= count_r + (JOB_PTR_W + 1)'(1);
      else if (rd && !wr) count_r <= count_r - (JOB_PTR_W + 1)'(1);
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wptr_r] <= wr_job;
  end

endmodule

@@ rtl/fcm_back.sv @@
module fcm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  fcm_pkg::job_t      job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output fcm_pkg::out_item_t out_item
);
  import fcm_pkg::*;

  logic      out_valid_r;
  out_item_t out_r, res;
  logic [2:0] cnt_r, cnt_nxt;
  logic      load;
  logic      job_done;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign load     = job_avail && (!out_valid_r || pop);
  assign job_pop  = load && job_done;

  // next result from the job at the head of the queue
  always_comb begin
    res      = '0;
    job_done = 1'b1;
    cnt_nxt  = cnt_r;
    unique case (job.kind)
      JOB_FWD: begin
        res.kind        = KIND_DUMP;
        res.dumped_byte = job.bytes[0];
        res.last        = 1'b1;
      end
      JOB_CMD: begin
        res.kind          = KIND_COMMAND;
        res.command_index = job.cmd_idx;
        res.arg_first     = job.args[0];
        res.arg_second    = job.args[1];
        res.arg_third     = job.args[2];
        res.last          = 1'b1;
      end
      JOB_DUMP: begin
        res.kind        = KIND_DUMP;
        res.dumped_byte = job.bytes[cnt_r];
        res.last        = cnt_r == 3'(job.len - 4'd1);
        job_done        = res.last;
      end
      default: begin
        res = '0;
      end
    endcase
    if (load) cnt_nxt = job_done ? 3'd0 : cnt_r + 3'd1;
  end

  // output register and byte counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= res;
  end

endmodule

@@ rtl/fixed_frame_command_matcher.sv @@
// fixed_frame_command_matcher: one byte transaction per cycle unless full.
// a byte's job is written to the job queue; its result is then registered out.
// a matched frame gives one result; an unmatched frame drains one dumped byte
// per cycle from the queue while the output is popped; this paces dump output.
// reset (synchronous, rst_n low) clears the fill count, queues and control registers;
// frame bytes are not cleared and need no clearing pass.
module fixed_frame_command_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  fcm_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output fcm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import fcm_pkg::*;

  logic in_accept;
  logic job_push, job_pop, job_avail;
  job_t job_in, job_head;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  // classifier and frame compare
  fcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_item   (in_item),
    .job_push  (job_push),
    .job       (job_in)
  );

  // job queue between the two sides
  fcm_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (job_push),
    .wr_job (job_in),
    .full   (full),
    .rd     (job_pop),
    .avail  (job_avail),
    .rd_job (job_head)
  );

  // result sequencer
  fcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (job_avail),
    .job       (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
